// ----- rtl/hcpa_pkg.sv -----
`default_nettype none

package hcpa_pkg;

    // Configuration port.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_PAIR_ID = 1'd1;

    localparam logic [15:0] RESET_PAIR_LIMIT = 16'd256;
    localparam logic [15:0] RESET_FIRST_PAIR_ID = 16'd1;
    // Pair limits below this value fall back to the default limit.
    localparam logic [15:0] SMALL_LIMIT = 16'd10;
    localparam logic [15:0] DEFAULT_LIMIT = 16'd256;

    // Lookup key is the (fore, back) color pair.
    localparam int KEY_W = 16;
    localparam int QUEUE_DEPTH = 2;

    // Quantizer constants.
    localparam logic [7:0] GRAY_DIFF_LIMIT = 8'd10;
    localparam logic [7:0] DARK_LIMIT = 8'd8;
    localparam logic [7:0] LIGHT_LIMIT = 8'd248;
    localparam logic [7:0] DARK_COLOR = 8'd16;
    localparam logic [7:0] LIGHT_COLOR = 8'd231;
    localparam logic [7:0] GRAY_BASE_COLOR = 8'd232;
    localparam logic [7:0] CUBE_BASE_COLOR = 8'd16;
    localparam logic [7:0] CUBE_RED_WEIGHT = 8'd36;
    localparam logic [7:0] CUBE_GREEN_WEIGHT = 8'd6;
    // A cube step is the number of these thresholds that a channel reaches.
    localparam logic [7:0] CUBE_T1 = 8'd26;
    localparam logic [7:0] CUBE_T2 = 8'd77;
    localparam logic [7:0] CUBE_T3 = 8'd128;
    localparam logic [7:0] CUBE_T4 = 8'd179;
    localparam logic [7:0] CUBE_T5 = 8'd230;
    // floor(sum / 3) is taken as (sum * 683) >> 11, exact for sums up to 765.
    localparam logic [19:0] THIRD_RECIP = 20'd683;
    localparam int THIRD_SHIFT = 11;
    // Ramp step is floor(((gray - 8) * 46 + 247) / 494); the division is a
    // multiply by 33962 and a shift by 24, exact for the 14-bit numerator.
    localparam logic [13:0] GRAY_STEP_MUL = 14'd46;
    localparam logic [13:0] GRAY_STEP_BIAS = 14'd247;
    localparam logic [29:0] GRAY_RECIP = 30'd33962;
    localparam int GRAY_RECIP_SHIFT = 24;

    typedef struct packed {
        logic       is_gray;
        logic [9:0] sum;
        logic [7:0] cube;
    } px_sum_t;

    typedef struct packed {
        logic       is_gray;
        logic [7:0] gray;
        logic [7:0] cube;
    } px_gray_t;

    typedef struct packed {
        logic        use_ramp;
        logic [13:0] num;
        logic [7:0]  color;
    } px_ramp_t;

    typedef struct packed {
        logic       new_image;
        logic [7:0] fore;
        logic [7:0] back;
    } cell_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  back;
        logic [7:0]  fore;
    } pair_entry_t;

    typedef struct packed {
        logic                   en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [2:0] cube_step(input logic [7:0] c);
        return {2'd0, c >= CUBE_T1} + {2'd0, c >= CUBE_T2} + {2'd0, c >= CUBE_T3}
             + {2'd0, c >= CUBE_T4} + {2'd0, c >= CUBE_T5};
    endfunction

    // First step: gray test, channel sum and the cube color.
    function automatic px_sum_t quant_sum(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        px_sum_t res;
        res.is_gray = (abs_diff(r, g) < GRAY_DIFF_LIMIT)
                   && (abs_diff(g, b) < GRAY_DIFF_LIMIT);
        res.sum = {2'd0, r} + {2'd0, g} + {2'd0, b};
        res.cube = CUBE_BASE_COLOR + {5'd0, cube_step(r)} * CUBE_RED_WEIGHT
                 + {5'd0, cube_step(g)} * CUBE_GREEN_WEIGHT + {5'd0, cube_step(b)};
        return res;
    endfunction

    // Second step: average of the three channels.
    function automatic px_gray_t quant_gray(input px_sum_t p);
        px_gray_t   res;
        logic [19:0] prod;
        prod = {10'd0, p.sum} * THIRD_RECIP;
        res.is_gray = p.is_gray;
        res.gray = prod[THIRD_SHIFT +: 8];
        res.cube = p.cube;
        return res;
    endfunction

    // Third step: pick the cube color or clamp the ramp ends; form the ramp numerator.
    function automatic px_ramp_t quant_ramp(input px_gray_t p);
        px_ramp_t res;
        res.use_ramp = 1'b0;
        res.num = {6'd0, p.gray - DARK_LIMIT} * GRAY_STEP_MUL + GRAY_STEP_BIAS;
        if (!p.is_gray) begin
            res.color = p.cube;
        end else if (p.gray < DARK_LIMIT) begin
            res.color = DARK_COLOR;
        end else if (p.gray > LIGHT_LIMIT) begin
            res.color = LIGHT_COLOR;
        end else begin
            res.color = GRAY_BASE_COLOR;
            res.use_ramp = 1'b1;
        end
        return res;
    endfunction

    // Last step: ramp position by reciprocal multiplication.
    function automatic logic [7:0] quant_color(input px_ramp_t p);
        logic [29:0] prod;
        prod = {16'd0, p.num} * GRAY_RECIP;
        return p.use_ramp ? (p.color + {3'd0, prod[GRAY_RECIP_SHIFT +: 5]}) : p.color;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hcpa_ram.sv -----
`default_nettype none

module hcpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/hcpa_fifo.sv -----
`default_nettype none

module hcpa_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire hcpa_pkg::cell_t push_data,
    output logic               push_ready,
    input  wire logic          pop,
    output hcpa_pkg::cell_t    head,
    output logic               head_valid
);

    import hcpa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cell_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hcpa_front.sv -----
`default_nettype none

module hcpa_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_new_image,
    input  wire logic [47:0]   in_pixels,
    output logic               cell_valid,
    output hcpa_pkg::cell_t    cell_out,
    input  wire logic          cell_ready
);

    import hcpa_pkg::*;

    typedef struct packed {
        logic    new_image;
        px_sum_t top;
        px_sum_t bot;
    } st_sum_t;

    typedef struct packed {
        logic     new_image;
        px_gray_t top;
        px_gray_t bot;
    } st_gray_t;

    typedef struct packed {
        logic     new_image;
        px_ramp_t top;
        px_ramp_t bot;
    } st_ramp_t;

    st_sum_t  sum_reg;
    st_gray_t gray_reg;
    st_ramp_t ramp_reg;
    logic     v1_reg, v2_reg, v3_reg;
    logic     rdy1, rdy2, rdy3;

    // Each stage moves when it is empty or the one after it moves.
    assign rdy3     = !v3_reg || cell_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            sum_reg.new_image <= in_new_image;
            sum_reg.top <= quant_sum(in_pixels[7:0], in_pixels[15:8], in_pixels[23:16]);
            sum_reg.bot <= quant_sum(in_pixels[31:24], in_pixels[39:32], in_pixels[47:40]);
        end
        if (rdy2)
        begin
            gray_reg.new_image <= sum_reg.new_image;
            gray_reg.top <= quant_gray(sum_reg.top);
            gray_reg.bot <= quant_gray(sum_reg.bot);
        end
        if (rdy3)
        begin
            ramp_reg.new_image <= gray_reg.new_image;
            ramp_reg.top <= quant_ramp(gray_reg.top);
            ramp_reg.bot <= quant_ramp(gray_reg.bot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign cell_valid         = v3_reg;
    assign cell_out.new_image = ramp_reg.new_image;
    assign cell_out.fore      = quant_color(ramp_reg.top);
    assign cell_out.back      = quant_color(ramp_reg.bot);

endmodule

`default_nettype wire

// ----- rtl/hcpa_alloc.sv -----
`default_nettype none

module hcpa_alloc #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hcpa_pkg::cfg_write_t cfg,
    input  wire logic                 head_valid,
    input  wire hcpa_pkg::cell_t      head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [31:0]               out_data,
    output logic                      out_created
);

    import hcpa_pkg::*;

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INDEX,
        S_SLOT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [15:0]        next_id_reg, next_id_next;
    logic [15:0]        limit_reg, limit_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               slot_ok_reg, slot_ok_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg, out_data_next;
    logic               out_created_reg, out_created_next;

    logic               idx_re, idx_we, pair_re, pair_we;
    logic [SLOT_W-1:0]  idx_rdata;
    pair_entry_t        pair_rdata, pair_wdata;
    logic [15:0]        eff_limit;
    logic               hit;

    // Sparse index: the key memory points to a slot, and the slot confirms the
    // key. A slot counts only below the fill count, so no clearing is needed.
    hcpa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (1 << KEY_W)
    ) u_index_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (key_reg),
        .wdata (count_reg[SLOT_W-1:0]),
        .re    (idx_re),
        .raddr ({head.fore, head.back}),
        .rdata (idx_rdata)
    );

    hcpa_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (count_reg[SLOT_W-1:0]),
        .wdata (pair_wdata),
        .re    (pair_re),
        .raddr (idx_rdata),
        .rdata (pair_rdata)
    );

    assign eff_limit = (limit_reg < SMALL_LIMIT) ? DEFAULT_LIMIT : limit_reg;
    assign hit = slot_ok_reg && (pair_rdata.fore == key_reg[15:8])
              && (pair_rdata.back == key_reg[7:0]);
    assign pair_wdata = '{id: next_id_reg, back: key_reg[7:0], fore: key_reg[15:8]};

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        next_id_next     = next_id_reg;
        limit_next       = limit_reg;
        key_next         = key_reg;
        slot_ok_next     = slot_ok_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;
        out_created_next = out_created_reg;
        pop     = 1'b0;
        idx_re  = 1'b0;
        idx_we  = 1'b0;
        pair_re = 1'b0;
        pair_we = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    idx_re   = 1'b1;
                    key_next = {head.fore, head.back};
                    if (head.new_image)
                    begin
                        count_next = '0;
                    end
                    state_next = S_INDEX;
                end
            end
            S_INDEX:
            begin
                pair_re      = 1'b1;
                slot_ok_next = (CNT_W'(idx_rdata) < count_reg);
                state_next   = S_SLOT;
            end
            S_SLOT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next[31:16] = key_reg;
                    out_created_next     = 1'b0;
                    if (hit)
                    begin
                        out_data_next[15:0] = pair_rdata.id;
                    end
                    else if (next_id_reg < eff_limit)
                    begin
                        out_data_next[15:0] = next_id_reg;
                        out_created_next    = 1'b1;
                        next_id_next        = next_id_reg + 16'd1;
                        if (count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            idx_we     = 1'b1;
                            pair_we    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        out_data_next[15:0] = 16'd0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.en)
        begin
            unique case (cfg.index)
                REG_PAIR_LIMIT:    limit_next = cfg.data;
                REG_FIRST_PAIR_ID: next_id_next = cfg.data;
                default:           limit_next = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            next_id_reg     <= RESET_FIRST_PAIR_ID;
            limit_reg       <= RESET_PAIR_LIMIT;
            key_reg         <= '0;
            slot_ok_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            out_created_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            next_id_reg     <= next_id_next;
            limit_reg       <= limit_next;
            key_reg         <= key_next;
            slot_ok_reg     <= slot_ok_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
            out_created_reg <= out_created_next;
        end
    end

    // The register holds {fore, back, id}; the bus wants {back, fore, id}.
    assign out_valid   = out_valid_reg;
    assign out_data    = {out_data_reg[23:16], out_data_reg[31:24], out_data_reg[15:0]};
    assign out_created = out_created_reg;

endmodule

`default_nettype wire

// ----- rtl/halfblock_color_pair_allocator.sv -----
// Half-block color pair allocator.
//
// Each slave-side transaction carries one character cell: a top and a bottom
// pixel in 8-bit RGB, plus a new-image flag in tuser that empties the pair
// table before the cell is handled. Both pixels are quantized to the
// 256-color palette, and the (foreground, background) pair is looked up; on
// a miss a new pair id is allocated while the counter is below the limit.
// Each cell gives exactly one master-side transaction.
//
// A cell goes through a three-stage quantizer, a two-entry queue and the
// allocator. For each cell the allocator makes one read of the key index
// memory, one dependent read of the pair slot memory, then the decision and
// table update, and it takes the next cell only after that decision.
//
// Reset empties the table (fill count zero), sets the pair limit to 256 and
// the id counter to 1; the memories need no clearing pass. When the receiver
// stalls, the result stays in the output register, the allocator waits in
// its decision step, the queue and quantizer fill, and then s_axis_tready
// drops. Configuration writes are taken at any edge with cfg_wr_en high.
`default_nettype none

module halfblock_color_pair_allocator #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [hcpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hcpa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
    input  wire logic [47:0]                      s_axis_tdata,
    // new_image
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // pair_id [15:0], fore_color [23:16], back_color [31:24]
    output logic [31:0]                           m_axis_tdata,
    // pair_created
    output logic                                  m_axis_tuser
);

    import hcpa_pkg::*;

    cfg_write_t cfg;
    cell_t      front_cell, head_cell;
    logic       front_valid, queue_ready;
    logic       head_valid, head_pop;

    assign cfg = '{en: cfg_wr_en, index: cfg_index, data: cfg_wdata};

    // Quantizer: accepts cells and turns the pixels into palette indexes.
    hcpa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_new_image (s_axis_tuser),
        .in_pixels    (s_axis_tdata),
        .cell_valid   (front_valid),
        .cell_out     (front_cell),
        .cell_ready   (queue_ready)
    );

    // Short queue so that the quantizer keeps taking cells while the
    // allocator is busy with a lookup.
    hcpa_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_data  (front_cell),
        .push_ready (queue_ready),
        .pop        (head_pop),
        .head       (head_cell),
        .head_valid (head_valid)
    );

    // Allocator: table lookup, id allocation and the output register.
    hcpa_alloc #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_alloc (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head_valid  (head_valid),
        .head        (head_cell),
        .pop         (head_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_created (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the half-block color pair allocator.
//
// Every cell that enters on the slave side is run through a predictor kept
// in this file: it quantizes both pixels to the 256-color palette, searches
// its own copy of the pair table and allocates ids the same way the block
// should. The prediction is queued at the edge where the cell is accepted,
// and every master-side transaction is compared field by field against the
// oldest queued prediction.
//
// The run starts with a short table of directed cells and register writes:
// black, white, primaries, the edges of the gray test and of the gray ramp,
// the small-limit fallback, the limit being reached, counter loads and the
// counter running on across images. A few of those rows carry an expected
// result written out by hand. Random phases follow, each with its own
// register settings. One of them stores more distinct pairs than the table
// holds, so allocations past a full table are seen.
//
// Both sides idle in rotating modes: none, sender idle, receiver stalling,
// and both at a light rate.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hcpa_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int POOL_SIZE = 8;
    localparam int MAX_GAP = 40;
    localparam int DRAIN_CYCLES = 20;
    localparam int MODE_SPAN = 73;

    typedef enum
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One master-side transaction as the predictor sees it.
    typedef struct packed
    {
        bit [15:0] pair_id;
        bit [7:0]  fore;
        bit [7:0]  back;
        bit        created;
    } pair_result_t;

    typedef struct packed
    {
        bit [7:0]  fore;
        bit [7:0]  back;
        bit [15:0] id;
    } pair_slot_t;

    // A row of the directed table is either a register write or a cell.
    typedef struct
    {
        bit                   is_cfg;
        bit [CFG_INDEX_W-1:0] cfg_index;
        bit [CFG_DATA_W-1:0]  cfg_value;
        bit                   new_image;
        bit [47:0]            pixels;
        bit                   known;
        pair_result_t         expected;
    } directed_row_t;

    typedef struct
    {
        bit [15:0] limit;
        bit [15:0] first_id;
        int        cells;
        bit        fill;
        int        new_image_pct;
    } test_phase_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
    logic [47:0]            s_axis_tdata = '0;
    // new_image
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // pair_id, fore_color, back_color
    logic [31:0]            m_axis_tdata;
    // pair_created
    logic                   m_axis_tuser;

    // Predictor state: its own pair table, fill count, id counter and the
    // two registers.
    pair_slot_t   pair_slots[TABLE_DEPTH];
    int unsigned  slot_count;
    bit [15:0]    id_counter;
    bit [15:0]    pair_limit_reg;
    bit [15:0]    first_id_reg;

    // Predictions waiting for their master-side transaction.
    pair_result_t pending_results[$];
    directed_row_t directed_rows[$];

    idle_mode_t   idle_mode = IDLE_NONE;
    int unsigned  fail_count = 0;
    int unsigned  cells_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  table_hits = 0;
    int unsigned  pairs_created = 0;
    int unsigned  limit_refusals = 0;
    int unsigned  full_table_drops = 0;

    halfblock_color_pair_allocator #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Palette index of one pixel. A pixel is gray when both neighbor
    // differences stay under 10; gray goes to the 24-step ramp with the
    // dark and light ends clamped, everything else to the 6x6x6 cube.
    function automatic bit [7:0] palette_index(input bit [7:0] r, input bit [7:0] g,
                                               input bit [7:0] b);
        int unsigned rg_diff;
        int unsigned gb_diff;
        int unsigned avg;
        rg_diff = (r > g) ? r - g : g - r;
        gb_diff = (g > b) ? g - b : b - g;
        if (rg_diff < 10 && gb_diff < 10)
        begin
            avg = (int'(r) + int'(g) + int'(b)) / 3;
            if (avg < 8)
                return 8'd16;
            if (avg > 248)
                return 8'd231;
            // Rounded (avg - 8) * 23 / 247, in integers.
            return 8'(232 + ((avg - 8) * 46 + 247) / 494);
        end
        // Each cube step is round(c * 5 / 255).
        return 8'(16 + 36 * ((int'(r) * 10 + 255) / 510)
                     + 6 * ((int'(g) * 10 + 255) / 510)
                     + (int'(b) * 10 + 255) / 510);
    endfunction

    // Handles one accepted cell in the predictor and returns its result.
    function automatic pair_result_t allocate_pair(input bit new_image,
                                                   input bit [47:0] pixels);
        pair_result_t res;
        int unsigned  k;
        int unsigned  eff_limit;
        bit           hit;
        if (new_image)
            slot_count = 0;
        res.fore = palette_index(pixels[7:0], pixels[15:8], pixels[23:16]);
        res.back = palette_index(pixels[31:24], pixels[39:32], pixels[47:40]);
        res.pair_id = '0;
        res.created = 1'b0;
        hit = 1'b0;
        for (k = 0; k < slot_count && !hit; k++)
        begin
            if (pair_slots[k].fore == res.fore && pair_slots[k].back == res.back)
            begin
                res.pair_id = pair_slots[k].id;
                hit = 1'b1;
            end
        end
        // Limits under 10 fall back to the default limit of 256.
        eff_limit = (pair_limit_reg < 10) ? 256 : pair_limit_reg;
        if (hit)
        begin
            table_hits++;
        end
        else if (id_counter < eff_limit)
        begin
            res.pair_id = id_counter;
            res.created = 1'b1;
            pairs_created++;
            if (slot_count < TABLE_DEPTH)
            begin
                pair_slots[slot_count] = '{res.fore, res.back, id_counter};
                slot_count++;
            end
            else
            begin
                full_table_drops++;
            end
            id_counter++;
        end
        else
        begin
            limit_refusals++;
        end
        return res;
    endfunction

    // Lays the six channels out the way s_axis_tdata carries them.
    function automatic bit [47:0] pack_cell(input bit [7:0] tr, input bit [7:0] tg,
                                            input bit [7:0] tb, input bit [7:0] br,
                                            input bit [7:0] bg, input bit [7:0] bb);
        return {bb, bg, br, tb, tg, tr};
    endfunction

    // A random pixel as {blue, green, red}. Unless only uniform values are
    // wanted, a good share is near-gray, straddling the gray test, and some
    // are made of channel extremes.
    function automatic bit [23:0] random_pixel(input bit uniform_only);
        bit [23:0] px;
        int        pick;
        int        base;
        int        v;
        int        ch;
        px = 24'($urandom);
        pick = $urandom_range(99);
        if (!uniform_only && pick < 35)
        begin
            base = $urandom_range(255);
            for (ch = 0; ch < 3; ch++)
            begin
                v = base + int'($urandom_range(24)) - 12;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                px[ch*8 +: 8] = v[7:0];
            end
        end
        else if (!uniform_only && pick < 45)
        begin
            for (ch = 0; ch < 3; ch++)
                px[ch*8 +: 8] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        end
        return px;
    endfunction

    // Number of idle cycles before the next cell, drawn geometrically.
    function automatic int idle_gap(input int pct);
        int n;
        n = 0;
        while (n < MAX_GAP && int'($urandom_range(99)) < pct)
            n++;
        return n;
    endfunction

    function automatic void add_cfg(input bit [CFG_INDEX_W-1:0] index,
                                    input bit [CFG_DATA_W-1:0] value);
        directed_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_index = index;
        row.cfg_value = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cell(input bit new_image, input bit [47:0] pixels);
        directed_row_t row;
        row = '{default: '0};
        row.new_image = new_image;
        row.pixels = pixels;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_known(input bit new_image, input bit [47:0] pixels,
                                      input bit [15:0] id, input bit [7:0] fore,
                                      input bit [7:0] back, input bit created);
        directed_row_t row;
        row = '{default: '0};
        row.new_image = new_image;
        row.pixels = pixels;
        row.known = 1'b1;
        row.expected = '{id, fore, back, created};
        directed_rows.push_back(row);
    endfunction

    // Drives one cell and waits until it is accepted. The prediction is
    // queued at the accepting edge; a hand-written expectation, when given,
    // replaces it while the predictor state still moves on.
    task automatic send_cell(input bit new_image, input bit [47:0] pixels,
                             input bit known, input pair_result_t expected);
        pair_result_t predicted;
        int           gap;
        idle_mode = idle_mode_t'((cells_sent / MODE_SPAN) % 4);
        gap = idle_gap((idle_mode == IDLE_SENDER) ? 68 : (idle_mode == IDLE_BOTH) ? 12 : 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixels;
        s_axis_tuser <= new_image;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = allocate_pair(new_image, pixels);
        pending_results.push_back(known ? expected : predicted);
        cells_sent++;
    endtask

    // Registers are only written once every queued result has come back.
    // The write strobe drops before the task returns, so a write that follows
    // at once starts at a later edge.
    task automatic write_register(input bit [CFG_INDEX_W-1:0] index,
                                  input bit [CFG_DATA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == REG_PAIR_LIMIT)
        begin
            pair_limit_reg = value;
        end
        else if (index == REG_FIRST_PAIR_ID)
        begin
            // Loading the first id also reloads the running counter.
            first_id_reg = value;
            id_counter = value;
        end
        @(posedge clk);
    endtask

    // Receiver: checks each accepted result against the oldest prediction
    // and stalls according to the current idle mode.
    initial
    begin
        pair_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[15:0] !== want.pair_id)
                    begin
                        $error("pair_id: expected %0d, actual %0d", want.pair_id,
                               m_axis_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[23:16] !== want.fore)
                    begin
                        $error("fore_color: expected %0d, actual %0d", want.fore,
                               m_axis_tdata[23:16]);
                        fail_count++;
                    end
                    if (m_axis_tdata[31:24] !== want.back)
                    begin
                        $error("back_color: expected %0d, actual %0d", want.back,
                               m_axis_tdata[31:24]);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.created)
                    begin
                        $error("pair_created: expected %0d, actual %0d", want.created,
                               m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= int'($urandom_range(99)) >=
                ((idle_mode == IDLE_RECEIVER) ? 68 : (idle_mode == IDLE_BOTH) ? 12 : 0);
        end
    end

    // A run that hangs is stopped here.
    initial
    begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        test_phase_t phases[5];
        bit [23:0]   pool[POOL_SIZE];
        bit [47:0]   seen_cells[$];
        bit [47:0]   pixels;
        bit          new_image;
        int          p;
        int          n;
        int          i;
        int          directed_cells;

        pair_limit_reg = RESET_PAIR_LIMIT;
        first_id_reg = RESET_FIRST_PAIR_ID;
        id_counter = RESET_FIRST_PAIR_ID;
        slot_count = 0;

        // Directed table. Rows with a result written out are the ones that
        // follow at a glance from register values, black, white and primaries.
        add_known(1'b1, pack_cell(0, 0, 0, 0, 0, 0), 16'd1, 8'd16, 8'd16, 1'b1);
        add_known(1'b0, pack_cell(255, 255, 255, 255, 255, 255), 16'd2, 8'd231, 8'd231, 1'b1);
        // Same pair again is found in the table.
        add_known(1'b0, pack_cell(0, 0, 0, 0, 0, 0), 16'd1, 8'd16, 8'd16, 1'b0);
        add_known(1'b0, pack_cell(255, 0, 0, 0, 0, 255), 16'd3, 8'd196, 8'd21, 1'b1);
        // Mid gray on top; the bottom is just inside the gray test.
        add_cell(1'b0, pack_cell(128, 128, 128, 9, 0, 0));
        // A difference of exactly 10 is not gray, 9 is.
        add_cell(1'b0, pack_cell(100, 110, 100, 100, 109, 100));
        // Both ends of the gray ramp, then just past them.
        add_cell(1'b0, pack_cell(8, 8, 8, 248, 248, 248));
        add_cell(1'b0, pack_cell(249, 249, 249, 7, 7, 7));
        add_cell(1'b0, pack_cell(255, 255, 0, 0, 255, 255));
        add_cell(1'b0, pack_cell(0, 255, 0, 255, 0, 255));
        // A limit under 10 falls back to 256, so allocation goes on.
        add_cfg(REG_PAIR_LIMIT, 16'd3);
        add_cell(1'b0, pack_cell(1, 2, 3, 60, 200, 90));
        // A limit of exactly 10 is taken as is: the counter is past it.
        add_cfg(REG_PAIR_LIMIT, 16'd10);
        add_known(1'b0, pack_cell(0, 0, 0, 255, 255, 255), 16'd0, 8'd16, 8'd231, 1'b0);
        add_known(1'b0, pack_cell(0, 0, 0, 0, 0, 0), 16'd1, 8'd16, 8'd16, 1'b0);
        // Loading the counter below the limit lets the refused pair in.
        add_cfg(REG_FIRST_PAIR_ID, 16'd9);
        add_known(1'b0, pack_cell(0, 0, 0, 255, 255, 255), 16'd9, 8'd16, 8'd231, 1'b1);
        add_cfg(REG_PAIR_LIMIT, 16'd9);
        add_known(1'b0, pack_cell(255, 0, 0, 255, 0, 0), 16'd10, 8'd196, 8'd196, 1'b1);
        // Id zero can be handed out like any other.
        add_cfg(REG_FIRST_PAIR_ID, 16'd0);
        add_known(1'b0, pack_cell(0, 0, 255, 0, 0, 255), 16'd0, 8'd21, 8'd21, 1'b1);
        add_cfg(REG_PAIR_LIMIT, 16'hFFFF);
        add_cfg(REG_FIRST_PAIR_ID, 16'hFFFE);
        add_known(1'b1, pack_cell(0, 0, 0, 0, 0, 0), 16'hFFFE, 8'd16, 8'd16, 1'b1);
        add_known(1'b0, pack_cell(255, 255, 255, 255, 255, 255), 16'd0, 8'd231, 8'd231, 1'b0);
        add_known(1'b0, pack_cell(0, 0, 0, 0, 0, 0), 16'hFFFE, 8'd16, 8'd16, 1'b0);
        // A new image empties the table but the counter keeps running.
        add_cfg(REG_FIRST_PAIR_ID, 16'd200);
        add_known(1'b1, pack_cell(255, 255, 255, 255, 255, 255), 16'd200, 8'd231, 8'd231,
                  1'b1);
        add_known(1'b1, pack_cell(255, 255, 255, 255, 255, 255), 16'd201, 8'd231, 8'd231,
                  1'b1);

        // Random phases: the first one overflows the table with distinct
        // pairs, the others use a small pixel pool so pairs repeat often.
        phases[0] = '{16'hFFFF, 16'd0, 1100, 1'b1, 0};
        phases[1] = '{16'd5, 16'd240, 15, 1'b0, 5};
        phases[2] = '{16'd10, 16'd0, 12, 1'b0, 5};
        phases[3] = '{16'hFFFF, 16'hFFFF, 10, 1'b0, 10};
        phases[4] = '{16'd0, 16'd200, 15, 1'b0, 20};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_register(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
            else
                send_cell(directed_rows[i].new_image, directed_rows[i].pixels,
                          directed_rows[i].known, directed_rows[i].expected);
        end
        directed_cells = cells_sent;

        for (p = 0; p < 5; p++)
        begin
            write_register(REG_PAIR_LIMIT, phases[p].limit);
            write_register(REG_FIRST_PAIR_ID, phases[p].first_id);
            for (i = 0; i < POOL_SIZE; i++)
                pool[i] = random_pixel(1'b0);
            for (n = 0; n < phases[p].cells; n++)
            begin
                if (phases[p].fill)
                begin
                    // Mostly fresh pairs, with a few repeats of earlier cells
                    // that either hit or, past a full table, miss again.
                    new_image = (n == 0);
                    if (seen_cells.size() != 0 && $urandom_range(99) < 3)
                        pixels = seen_cells[$urandom_range(seen_cells.size() - 1)];
                    else
                        pixels = {random_pixel(1'b1), random_pixel(1'b1)};
                    seen_cells.push_back(pixels);
                end
                else
                begin
                    new_image = int'($urandom_range(99)) < phases[p].new_image_pct;
                    pixels = {pool[$urandom_range(POOL_SIZE - 1)],
                              pool[$urandom_range(POOL_SIZE - 1)]};
                end
                send_cell(new_image, pixels, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d cells (%0d directed) and checked %0d results over 5 register settings.",
                 cells_sent, directed_cells, results_seen);
        $display("Pairs created %0d, table hits %0d, refused at limit %0d, not stored %0d.",
                 pairs_created, table_hits, limit_refusals, full_table_drops);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/hcpa_pkg.sv
rtl/hcpa_ram.sv
rtl/hcpa_fifo.sv
rtl/hcpa_front.sv
rtl/hcpa_alloc.sv
rtl/halfblock_color_pair_allocator.sv
tb/tb_top.sv
